>>> src/tcphb_pkg.sv
// Shared codes, constants, types and checksum helpers for the TCP header builder.
package tcphb_pkg;

   localparam logic [1:0] OP_HEADER = 2'd0;
   localparam logic [1:0] OP_PSEUDO = 2'd1;
   localparam logic [1:0] OP_BYTE   = 2'd2;
   localparam logic [1:0] OP_FINISH = 2'd3;

   localparam int HDR_WORDS_MAX  = 14;
   localparam int CNT_W          = $clog2(HDR_WORDS_MAX + 1);
   localparam logic [CNT_W-1:0] HDR_WORDS_BASE = CNT_W'(10);
   localparam logic [CNT_W-1:0] HDR_WORDS_ONE  = CNT_W'(12);
   localparam logic [CNT_W-1:0] HDR_WORDS_TWO  = CNT_W'(14);

   localparam logic [3:0]  DATA_OFFSET_BASE = 4'd5;
   localparam logic [15:0] MSS_KIND_LEN     = 16'h0204;
   localparam logic [15:0] WS_KIND_LEN      = 16'h0303;
   localparam logic [7:0]  NOP_BYTE         = 8'h01;
   // header sum of an all-zero descriptor: only the data offset word is non-zero
   localparam logic [15:0] HDR_SUM_RESET    = {DATA_OFFSET_BASE, 12'h000};

   typedef logic [15:0] word_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [5:0]  flag_bits;
      logic [15:0] window_size;
      logic [15:0] urgent_pointer;
      logic [1:0]  option_mask;
      logic [15:0] mss_size;
      logic [7:0]  scale_shift;
      logic [15:0] data_word;
      logic [17:0] part_a;
      logic [17:0] part_b;
      logic [17:0] part_c;
   } stage_type;

   typedef struct packed {
      logic                 load;
      logic [CNT_W-1:0]     count;
      word_type [HDR_WORDS_MAX-1:0] words;
   } load_type;

   // end-around carry fold of an 18-bit sum into 16 bits
   function automatic logic [15:0] fold18(input logic [17:0] x);
      logic [16:0] s;
      s = {1'b0, x[15:0]} + {15'd0, x[17:16]};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [15:0] fold20(input logic [19:0] x);
      logic [16:0] s;
      s = {1'b0, x[15:0]} + {13'd0, x[19:16]};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      return fold18({2'b00, a} + {2'b00, b});
   endfunction

endpackage

>>> src/tcphb_req_if.sv
// Request channel: one input word per handshake.
interface tcphb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [31:0] seq_number;
   logic [31:0] ack_number;
   logic [5:0]  flag_bits;
   logic [15:0] window_size;
   logic [15:0] urgent_pointer;
   logic [1:0]  option_mask;
   logic [15:0] mss_size;
   logic [7:0]  scale_shift;
   logic [15:0] data_word;

   modport source (output valid, opcode, sport, dport, seq_number, ack_number,
                   flag_bits, window_size, urgent_pointer, option_mask, mss_size,
                   scale_shift, data_word, input ready);
   modport sink (input valid, opcode, sport, dport, seq_number, ack_number,
                 flag_bits, window_size, urgent_pointer, option_mask, mss_size,
                 scale_shift, data_word, output ready);
endinterface

>>> src/tcphb_rsp_if.sv
// Response channel: one header word per handshake.
interface tcphb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] header_word;
   logic        last_word;

   modport source (output valid, header_word, last_word, input ready);
   modport sink (input valid, header_word, last_word, output ready);
endinterface

>>> src/tcphb_in_stage.sv
// Input register with header partial sums formed on the way in.
module tcphb_in_stage import tcphb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tcphb_req_if.sink req_chan,
   input  logic      take,
   output logic      stage_valid,
   output stage_type stage
);

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;
   logic [3:0]  offset;
   logic [17:0] opt_mss, opt_ws;
   logic        accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      offset  = DATA_OFFSET_BASE + {3'd0, req_chan.option_mask[0]}
                + {3'd0, req_chan.option_mask[1]};
      opt_mss = req_chan.option_mask[0] ?
                ({2'b00, MSS_KIND_LEN} + {2'b00, req_chan.mss_size}) : 18'd0;
      opt_ws  = req_chan.option_mask[1] ?
                ({2'b00, WS_KIND_LEN} + {2'b00, req_chan.scale_shift, NOP_BYTE}) : 18'd0;

      stage_in                = stage_ff;
      stage_in.opcode         = req_chan.opcode;
      stage_in.sport          = req_chan.sport;
      stage_in.dport          = req_chan.dport;
      stage_in.seq_number     = req_chan.seq_number;
      stage_in.ack_number     = req_chan.ack_number;
      stage_in.flag_bits      = req_chan.flag_bits;
      stage_in.window_size    = req_chan.window_size;
      stage_in.urgent_pointer = req_chan.urgent_pointer;
      stage_in.option_mask    = req_chan.option_mask;
      stage_in.mss_size       = req_chan.mss_size;
      stage_in.scale_shift    = req_chan.scale_shift;
      stage_in.data_word      = req_chan.data_word;
      stage_in.part_a = {2'b00, req_chan.sport} + {2'b00, req_chan.dport}
                      + {2'b00, req_chan.seq_number[31:16]}
                      + {2'b00, req_chan.seq_number[15:0]};
      stage_in.part_b = {2'b00, req_chan.ack_number[31:16]}
                      + {2'b00, req_chan.ack_number[15:0]}
                      + {2'b00, req_chan.window_size} + {2'b00, req_chan.urgent_pointer};
      stage_in.part_c = {2'b00, offset, 6'd0, req_chan.flag_bits} + opt_mss + opt_ws;

      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

>>> src/tcphb_sum_core.sv
// Held header fields, running ones' complement sum and header assembly at finish.
module tcphb_sum_core import tcphb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_valid,
   input  stage_type stage,
   input  logic      emit_free,
   output logic      take,
   output load_type  load
);

   logic [15:0] src_ff, dst_ff, window_ff, urgent_ff, mss_ff;
   logic [31:0] seq_ff, ack_ff;
   logic [5:0]  flags_ff;
   logic [1:0]  options_ff;
   logic [7:0]  scale_ff;
   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] run_ff, run_in;
   logic [7:0]  pend_ff, pend_in;
   logic        odd_ff, odd_in;
   logic        is_header, is_finish;
   logic [3:0]  offset;
   logic [15:0] checksum;
   logic [15:0] pad;

   assign is_header = stage_valid && stage.opcode == OP_HEADER;
   assign is_finish = stage.opcode == OP_FINISH;
   assign take      = stage_valid && (!is_finish || emit_free);

   always_comb begin
      hsum_in = hsum_ff;
      run_in  = run_ff;
      pend_in = pend_ff;
      odd_in  = odd_ff;
      if (take) begin
         case (stage.opcode)
            OP_HEADER: begin
               hsum_in = fold20({2'b00, stage.part_a} + {2'b00, stage.part_b}
                                + {2'b00, stage.part_c});
            end
            OP_PSEUDO: begin
               run_in = oc_add(run_ff, stage.data_word);
            end
            OP_BYTE: begin
               if (!odd_ff) begin
                  pend_in = stage.data_word[7:0];
                  odd_in  = 1'b1;
               end else begin
                  run_in  = oc_add(run_ff, {pend_ff, stage.data_word[7:0]});
                  pend_in = 8'd0;
                  odd_in  = 1'b0;
               end
            end
            default: begin
               run_in  = 16'd0;
               pend_in = 8'd0;
               odd_in  = 1'b0;
            end
         endcase
      end
   end

   // pad an odd trailing byte with a zero low byte
   assign pad      = odd_ff ? {pend_ff, 8'd0} : 16'd0;
   assign checksum = ~fold18({2'b00, run_ff} + {2'b00, pad} + {2'b00, hsum_ff});
   assign offset   = DATA_OFFSET_BASE + {3'd0, options_ff[0]} + {3'd0, options_ff[1]};

   always_comb begin
      load.load     = take && is_finish;
      load.words    = '0;
      load.words[0] = src_ff;
      load.words[1] = dst_ff;
      load.words[2] = seq_ff[31:16];
      load.words[3] = seq_ff[15:0];
      load.words[4] = ack_ff[31:16];
      load.words[5] = ack_ff[15:0];
      load.words[6] = {offset, 6'd0, flags_ff};
      load.words[7] = window_ff;
      load.words[8] = checksum;
      load.words[9] = urgent_ff;
      case (options_ff)
         2'b01: begin
            load.count     = HDR_WORDS_ONE;
            load.words[10] = MSS_KIND_LEN;
            load.words[11] = mss_ff;
         end
         2'b10: begin
            load.count     = HDR_WORDS_ONE;
            load.words[10] = WS_KIND_LEN;
            load.words[11] = {scale_ff, NOP_BYTE};
         end
         2'b11: begin
            load.count     = HDR_WORDS_TWO;
            load.words[10] = MSS_KIND_LEN;
            load.words[11] = mss_ff;
            load.words[12] = WS_KIND_LEN;
            load.words[13] = {scale_ff, NOP_BYTE};
         end
         default: begin
            load.count = HDR_WORDS_BASE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff     <= 16'd0;
         dst_ff     <= 16'd0;
         seq_ff     <= 32'd0;
         ack_ff     <= 32'd0;
         flags_ff   <= 6'd0;
         window_ff  <= 16'd0;
         urgent_ff  <= 16'd0;
         options_ff <= 2'd0;
         mss_ff     <= 16'd0;
         scale_ff   <= 8'd0;
         hsum_ff    <= HDR_SUM_RESET;
         run_ff     <= 16'd0;
         pend_ff    <= 8'd0;
         odd_ff     <= 1'b0;
      end else begin
         if (is_header) begin
            src_ff     <= stage.sport;
            dst_ff     <= stage.dport;
            seq_ff     <= stage.seq_number;
            ack_ff     <= stage.ack_number;
            flags_ff   <= stage.flag_bits;
            window_ff  <= stage.window_size;
            urgent_ff  <= stage.urgent_pointer;
            options_ff <= stage.option_mask;
            mss_ff     <= stage.mss_size;
            scale_ff   <= stage.scale_shift;
         end
         hsum_ff <= hsum_in;
         run_ff  <= run_in;
         pend_ff <= pend_in;
         odd_ff  <= odd_in;
      end
   end

endmodule

>>> src/tcphb_emitter.sv
// Header word shift buffer that drives the response channel.
module tcphb_emitter import tcphb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  load_type    load,
   output logic        emit_free,
   tcphb_rsp_if.source rsp_chan
);

   word_type [HDR_WORDS_MAX-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             fire;

   assign rsp_chan.valid       = remain_ff != '0;
   assign rsp_chan.header_word = buf_ff[0];
   assign rsp_chan.last_word   = remain_ff == CNT_W'(1);
   assign fire                 = rsp_chan.valid && rsp_chan.ready;
   assign emit_free            = remain_ff == '0 || (remain_ff == CNT_W'(1) && rsp_chan.ready);

   always_comb begin
      buf_in    = buf_ff;
      remain_in = remain_ff;
      if (load.load) begin
         buf_in    = load.words;
         remain_in = load.count;
      end else if (fire) begin
         // advance the queue by one word
         for (int i = 0; i < HDR_WORDS_MAX - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
      buf_ff <= buf_in;
   end

endmodule

>>> src/tcp_header_builder_checksum.sv
// Top level of the TCP header builder with Internet checksum.
// Usage:
//   req_chan carries one word per valid/ready handshake: a header descriptor,
//   a pseudo-header word, a payload byte or a finish command (opcode field).
//   Descriptor, pseudo-header and byte words produce no response and are taken
//   at one per cycle, back to back, as long as the input register can drain.
//   A finish word is answered on rsp_chan with 10, 12 or 14 header words in
//   network order; last_word marks the final one and word 8 holds the checksum.
//   A finish word passes from the input register to the response buffer once
//   it is free; one word then leaves per cycle that rsp_chan.ready is high.
//   The response words sit in a shift buffer, so descriptors, pseudo-header
//   words and bytes of the next packet keep flowing while a header drains.
//   A second finish waits in the input register until the last word of the
//   header before it is taken, which holds req_chan.ready low meanwhile.
//   A stalled receiver simply holds the current word; nothing is dropped.
//   Reset (synchronous, active high) clears the held fields to zero, empties
//   the running sum and the response buffer.
module tcp_header_builder_checksum import tcphb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tcphb_req_if.sink   req_chan,
   tcphb_rsp_if.source rsp_chan
);

   stage_type stage;
   logic      stage_valid;
   logic      take;
   logic      emit_free;
   load_type  load;

   tcphb_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .take        (take),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   tcphb_sum_core u_sum_core (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .emit_free   (emit_free),
      .take        (take),
      .load        (load)
   );

   tcphb_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .emit_free (emit_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> test/testbench.sv
// Self-checking testbench for the TCP header builder: directed rows, then random packets.
module testbench;
   import tcphb_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_ITEMS    = 125;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 16;
   localparam int LIMIT_CYCLES    = 200000;
   // checksum of a header built from all-zero held fields and an empty sum
   localparam logic [15:0] ZERO_HEADER_SUM = 16'hAFFF;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [5:0]  flag_bits;
      logic [15:0] window_size;
      logic [15:0] urgent_pointer;
      logic [1:0]  option_mask;
      logic [15:0] mss_size;
      logic [7:0]  scale_shift;
      logic [15:0] data_word;
   } req_word_type;

   typedef struct packed {
      word_type word;
      logic     last;
   } header_entry_type;

   typedef struct packed {
      req_word_type item;
      logic         sum_fixed;
      logic [15:0]  sum_value;
   } stim_row_type;

   logic clock;
   logic reset;

   tcphb_req_if req_chan ();
   tcphb_rsp_if rsp_chan ();

   tcp_header_builder_checksum dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow of the block's state
   req_word_type held;
   logic [15:0]  sum_acc;
   logic [7:0]   pending_hi;
   logic         odd_phase;

   header_entry_type header_due [$];
   stim_row_type     stim_rows [$];
   int  error_count;
   int  items_sent;
   int  stalls_wanted;
   logic calm;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("tcp_header_builder_checksum: mismatch");
      $finish;
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // fold one accepted word into the shadow state; a finish queues the header it causes
   task automatic advance_builder(input req_word_type w, input logic sum_fixed,
                                  input logic [15:0] sum_value);
      logic [15:0] hdr [HDR_WORDS_MAX];
      logic [15:0] acc;
      logic [3:0]  offset;
      int          n;
      case (w.opcode)
         OP_HEADER: held = w;
         OP_PSEUDO: sum_acc = ones_add(sum_acc, w.data_word);
         OP_BYTE: begin
            if (!odd_phase) begin
               pending_hi = w.data_word[7:0];
               odd_phase  = 1'b1;
            end else begin
               sum_acc    = ones_add(sum_acc, {pending_hi, w.data_word[7:0]});
               pending_hi = 8'd0;
               odd_phase  = 1'b0;
            end
         end
         OP_FINISH: begin
            offset = DATA_OFFSET_BASE + {3'd0, held.option_mask[0]}
                     + {3'd0, held.option_mask[1]};
            hdr[0] = held.sport;
            hdr[1] = held.dport;
            hdr[2] = held.seq_number[31:16];
            hdr[3] = held.seq_number[15:0];
            hdr[4] = held.ack_number[31:16];
            hdr[5] = held.ack_number[15:0];
            hdr[6] = {offset, 6'd0, held.flag_bits};
            hdr[7] = held.window_size;
            hdr[8] = 16'd0;
            hdr[9] = held.urgent_pointer;
            n = 10;
            if (held.option_mask[0]) begin
               hdr[n]     = MSS_KIND_LEN;
               hdr[n + 1] = held.mss_size;
               n = n + 2;
            end
            if (held.option_mask[1]) begin
               hdr[n]     = WS_KIND_LEN;
               hdr[n + 1] = {held.scale_shift, NOP_BYTE};
               n = n + 2;
            end
            acc = sum_acc;
            // pad a trailing odd byte with a zero low byte
            if (odd_phase)
               acc = ones_add(acc, {pending_hi, 8'h00});
            for (int k = 0; k < n; k++)
               acc = ones_add(acc, hdr[k]);
            hdr[8] = sum_fixed ? sum_value : ~acc;
            for (int k = 0; k < n; k++)
               header_due.push_back('{word: hdr[k], last: (k == n - 1)});
            sum_acc    = 16'd0;
            pending_hi = 8'd0;
            odd_phase  = 1'b0;
         end
      endcase
   endtask

   task automatic put_fields(input req_word_type w);
      req_chan.opcode         <= w.opcode;
      req_chan.sport          <= w.sport;
      req_chan.dport          <= w.dport;
      req_chan.seq_number     <= w.seq_number;
      req_chan.ack_number     <= w.ack_number;
      req_chan.flag_bits      <= w.flag_bits;
      req_chan.window_size    <= w.window_size;
      req_chan.urgent_pointer <= w.urgent_pointer;
      req_chan.option_mask    <= w.option_mask;
      req_chan.mss_size       <= w.mss_size;
      req_chan.scale_shift    <= w.scale_shift;
      req_chan.data_word      <= w.data_word;
   endtask

   // offer one word; valid stays high after acceptance unless the next call idles
   task automatic offer(input req_word_type w, input logic sum_fixed,
                        input logic [15:0] sum_value);
      while (!calm && $urandom_range(99) < 6) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      put_fields(w);
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      advance_builder(w, sum_fixed, sum_value);
      items_sent++;
   endtask

   function automatic req_word_type plain_item(input logic [1:0] op, input logic [15:0] data);
      req_word_type w;
      w           = '0;
      w.opcode    = op;
      w.data_word = data;
      return w;
   endfunction

   function automatic req_word_type descriptor_item(
      input logic [15:0] src, input logic [15:0] dst, input logic [31:0] seq,
      input logic [31:0] ack, input logic [5:0] flags, input logic [15:0] win,
      input logic [15:0] urg, input logic [1:0] opts, input logic [15:0] mss,
      input logic [7:0] scale);
      req_word_type w;
      w                = '0;
      w.opcode         = OP_HEADER;
      w.sport          = src;
      w.dport          = dst;
      w.seq_number     = seq;
      w.ack_number     = ack;
      w.flag_bits      = flags;
      w.window_size    = win;
      w.urgent_pointer = urg;
      w.option_mask    = opts;
      w.mss_size       = mss;
      w.scale_shift    = scale;
      return w;
   endfunction

   function automatic stim_row_type row(input req_word_type w, input logic fixed = 1'b0,
                                        input logic [15:0] value = 16'd0);
      return '{item: w, sum_fixed: fixed, sum_value: value};
   endfunction

   // every field random, unused ones too, so that all bits toggle
   function automatic req_word_type random_item(input logic [1:0] op);
      req_word_type w;
      w.opcode         = op;
      w.sport          = 16'($urandom);
      w.dport          = 16'($urandom);
      w.seq_number     = 32'($urandom);
      w.ack_number     = 32'($urandom);
      w.flag_bits      = 6'($urandom);
      w.window_size    = 16'($urandom);
      w.urgent_pointer = 16'($urandom);
      w.option_mask    = 2'($urandom);
      w.mss_size       = 16'($urandom);
      w.scale_shift    = 8'($urandom);
      w.data_word      = 16'($urandom);
      return w;
   endfunction

   // descriptor if requested, pseudo-header words mixed among payload bytes, then finish
   task automatic send_packet(input logic fresh_descriptor);
      int bytes_left;
      int pseudo_left;
      bytes_left  = ($urandom_range(15) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 9);
      pseudo_left = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 6;
      if (fresh_descriptor)
         offer(random_item(OP_HEADER), 1'b0, 16'd0);
      while (bytes_left + pseudo_left > 0) begin
         if (pseudo_left > 0 &&
             $urandom_range(bytes_left + pseudo_left - 1) < pseudo_left) begin
            offer(random_item(OP_PSEUDO), 1'b0, 16'd0);
            pseudo_left--;
         end else begin
            offer(random_item(OP_BYTE), 1'b0, 16'd0);
            bytes_left--;
         end
      end
      offer(random_item(OP_FINISH), 1'b0, 16'd0);
   endtask

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int hold;
      int served;
      hold   = 0;
      served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_wanted != served) begin
            served = stalls_wanted;
            hold   = RSP_HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < 6) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare each header word taken from the block with the oldest one due
   initial begin
      header_entry_type want;
      int seen;
      seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (header_due.size() == 0) begin
               report_mismatch($sformatf("header word %h arrived with none due",
                                         rsp_chan.header_word));
            end else begin
               want = header_due.pop_front();
               if (rsp_chan.header_word !== want.word)
                  report_mismatch($sformatf("word %0d: header_word %h, predicted %h",
                                            seen, rsp_chan.header_word, want.word));
               if (rsp_chan.last_word !== want.last)
                  report_mismatch($sformatf("word %0d: last_word %b, predicted %b",
                                            seen, rsp_chan.last_word, want.last));
            end
            seen++;
         end
      end
   end

   initial begin
      int pkt;
      error_count   = 0;
      items_sent    = 0;
      held          = '0;
      sum_acc       = 16'd0;
      pending_hi    = 8'd0;
      odd_phase     = 1'b0;
      stalls_wanted <= 0;
      calm          <= 1'b0;
      reset         <= 1'b1;
      req_chan.valid <= 1'b0;
      put_fields('0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // finish straight after reset: only the data offset and checksum words are non-zero
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'h0000), 1'b1, ZERO_HEADER_SUM));
      // upper bits of a payload word are ignored; odd byte stays pending over a pseudo word
      stim_rows.push_back(row(plain_item(OP_BYTE, 16'hFFAB)));
      stim_rows.push_back(row(plain_item(OP_PSEUDO, 16'hFFFF)));
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'h0000)));
      stim_rows.push_back(row(descriptor_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                              32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 16'hFFFF,
                                              2'b11, 16'hFFFF, 8'hFF)));
      stim_rows.push_back(row(plain_item(OP_PSEUDO, 16'h0000)));
      stim_rows.push_back(row(plain_item(OP_BYTE, 16'h0000)));
      stim_rows.push_back(row(plain_item(OP_BYTE, 16'h00FF)));
      stim_rows.push_back(row(plain_item(OP_PSEUDO, 16'h8001)));
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'hFFFF)));
      stim_rows.push_back(row(descriptor_item(16'h1234, 16'h0050, 32'h0000_0000,
                                              32'h8000_0000, 6'h12, 16'h0000, 16'h0000,
                                              2'b01, 16'h05B4, 8'h00)));
      stim_rows.push_back(row(plain_item(OP_BYTE, 16'h0045)));
      stim_rows.push_back(row(plain_item(OP_BYTE, 16'h5A00)));
      stim_rows.push_back(row(plain_item(OP_BYTE, 16'h007F)));
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'h0000)));
      stim_rows.push_back(row(descriptor_item(16'h8000, 16'h0001, 32'h0001_0000,
                                              32'h0000_FFFF, 6'h21, 16'h7FFF, 16'h8000,
                                              2'b10, 16'h0000, 8'h0E)));
      stim_rows.push_back(row(plain_item(OP_PSEUDO, 16'hC0A8)));
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'h0000)));
      stim_rows.push_back(row(descriptor_item(16'h0000, 16'h0000, 32'h0, 32'h0, 6'h00,
                                              16'h0000, 16'h0000, 2'b00, 16'h0000,
                                              8'h00)));
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'h0000), 1'b1, ZERO_HEADER_SUM));
      // held fields survive a finish
      stim_rows.push_back(row(plain_item(OP_FINISH, 16'h0000), 1'b1, ZERO_HEADER_SUM));

      foreach (stim_rows[i])
         offer(stim_rows[i].item, stim_rows[i].sum_fixed, stim_rows[i].sum_value);

      pkt = 0;
      while (items_sent < stim_rows.size() + RANDOM_ITEMS) begin
         if (pkt == 2)
            stalls_wanted <= stalls_wanted + 1;
         if (pkt == 6) begin
            // hold the sender until every header word has drained
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (header_due.size() != 0) @(posedge clock);
         end
         calm <= (pkt >= 7 && pkt <= 10);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4))
               offer(random_item(2'($urandom_range(3))), 1'b0, 16'd0);
         end else begin
            send_packet($urandom_range(4) != 0);
         end
         pkt++;
      end
      req_chan.valid <= 1'b0;

      while (header_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tcp_header_builder_checksum: match");
      else
         $display("tcp_header_builder_checksum: mismatch");
      $finish;
   end

endmodule
